// ===== sv/msc_pkg.sv =====
// ----------------------------------------------------------------------------
// msc_pkg
// Shared types, constants and case tables for the marching squares cell unit.
// ----------------------------------------------------------------------------
package msc_pkg;

	// fixed port widths
	localparam int unsigned COORD_W       = 8;
	localparam int unsigned SAMPLE_PORT_W = 16;
	localparam int unsigned POINT_W       = 16;
	localparam int unsigned CASE_W        = 4;
	localparam int unsigned FRAC_W        = 8;

	// defaults for the top-level parameters
	localparam int unsigned GRID_CELLS_DEF  = 256;
	localparam int unsigned SAMPLE_BITS_DEF = 16;

	// divider pipeline: quotient bits retired per stage, and stage count
	localparam int unsigned BITS_PER_STAGE = 2;
	localparam int unsigned DIV_STAGES     = FRAC_W / BITS_PER_STAGE;

	localparam int unsigned NUM_EDGES = 4;

	// edge codes (bottom ll->lr, left ll->ul, right lr->ur, top ul->ur)
	typedef logic [1:0] edge_t;
	localparam edge_t EDGE_BOTTOM = 2'd0;
	localparam edge_t EDGE_LEFT   = 2'd1;
	localparam edge_t EDGE_RIGHT  = 2'd2;
	localparam edge_t EDGE_TOP    = 2'd3;

	typedef logic [FRAC_W-1:0] frac_t;
	typedef logic [POINT_W-1:0] point_t;

	// cell info that travels down the pipeline beside the divider lanes
	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [CASE_W-1:0]  idx;
	} cell_t;

	// one line segment
	typedef struct packed {
		point_t sx;
		point_t sy;
		point_t ex;
		point_t ey;
	} seg_t;

	// number of segments a case emits
	function automatic logic [1:0] seg_count(input logic [CASE_W-1:0] idx);
		logic [1:0] n;
		case (idx) inside
			4'd0, 4'd15: n = 2'd0;
			4'd5, 4'd10: n = 2'd2;
			default:     n = 2'd1;
		endcase
		return n;
	endfunction

	// edge for a case at slot: 0/1 first segment, 2/3 second segment
	function automatic edge_t seg_edge(input logic [CASE_W-1:0] idx, input logic [1:0] slot);
		edge_t a, b, c, d;
		a = EDGE_BOTTOM; b = EDGE_BOTTOM; c = EDGE_BOTTOM; d = EDGE_BOTTOM;
		case (idx) inside
			4'd1, 4'd14: begin a = EDGE_LEFT;   b = EDGE_TOP;    end
			4'd2, 4'd13: begin a = EDGE_RIGHT;  b = EDGE_TOP;    end
			4'd3, 4'd12: begin a = EDGE_LEFT;   b = EDGE_RIGHT;  end
			4'd4, 4'd11: begin a = EDGE_BOTTOM; b = EDGE_RIGHT;  end
			4'd6, 4'd9:  begin a = EDGE_TOP;    b = EDGE_BOTTOM; end
			4'd7, 4'd8:  begin a = EDGE_BOTTOM; b = EDGE_LEFT;   end
			4'd5: begin
				a = EDGE_BOTTOM; b = EDGE_RIGHT; c = EDGE_LEFT; d = EDGE_TOP;
			end
			4'd10: begin
				a = EDGE_BOTTOM; b = EDGE_LEFT; c = EDGE_RIGHT; d = EDGE_TOP;
			end
			default: begin end
		endcase
		case (slot)
			2'd0:    return a;
			2'd1:    return b;
			2'd2:    return c;
			default: return d;
		endcase
	endfunction

endpackage

// ===== sv/msc_frac_div.sv =====
// ----------------------------------------------------------------------------
// msc_frac_div
// Pipelined restoring divider for one edge: frac = (num << 8) / den, 0.8
// unsigned, saturating at 255/256. den is nonzero on any crossed edge.
// ----------------------------------------------------------------------------
module msc_frac_div #(
	parameter int unsigned DW = 17
) (
	input  logic                                  clk,
	input  logic [msc_pkg::DIV_STAGES-1:0]        en,
	input  logic [DW-1:0]                         num,
	input  logic [DW-1:0]                         den,
	output msc_pkg::frac_t                        frac
);
	import msc_pkg::*;

	logic [DW-1:0] rem_in  [DIV_STAGES];
	frac_t         quo_in  [DIV_STAGES];
	logic [DW-1:0] den_in  [DIV_STAGES];
	logic          ovf_in  [DIV_STAGES];

	logic [DW-1:0] rem_sn  [DIV_STAGES];
	frac_t         quo_sn  [DIV_STAGES];
	logic [DW-1:0] den_sn  [DIV_STAGES];
	logic          ovf_sn  [DIV_STAGES];

	// seed: a quotient of one or more saturates
	always_comb begin
		rem_in[0] = (num >= den) ? '0 : num;
		quo_in[0] = '0;
		den_in[0] = den;
		ovf_in[0] = (num >= den) && (den != '0);
	end

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic [DW-1:0] rem_nx;
		frac_t         quo_nx;

		if (g > 0) begin : g_link
			always_comb begin
				rem_in[g] = rem_sn[g-1];
				quo_in[g] = quo_sn[g-1];
				den_in[g] = den_sn[g-1];
				ovf_in[g] = ovf_sn[g-1];
			end
		end

		// BITS_PER_STAGE shift-subtract steps
		always_comb begin
			logic [DW:0] r2;
			rem_nx = rem_in[g];
			quo_nx = quo_in[g];
			for (int k = 0; k < BITS_PER_STAGE; k++) begin
				r2 = {rem_nx, 1'b0};
				if (r2 >= {1'b0, den_in[g]}) begin
					r2     = r2 - {1'b0, den_in[g]};
					quo_nx = {quo_nx[FRAC_W-2:0], 1'b1};
				end else begin
					quo_nx = {quo_nx[FRAC_W-2:0], 1'b0};
				end
				rem_nx = r2[DW-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en[g]) begin
				rem_sn[g] <= rem_nx;
				quo_sn[g] <= quo_nx;
				den_sn[g] <= den_in[g];
				ovf_sn[g] <= ovf_in[g];
			end
		end
	end

	assign frac = ovf_sn[DIV_STAGES-1] ? '1 : quo_sn[DIV_STAGES-1];

endmodule

// ===== sv/msc_seg_out.sv =====
// ----------------------------------------------------------------------------
// msc_seg_out
// Output stage: forms the edge crossing points of a cell and hands out its
// one or two segments, one transfer each.
// ----------------------------------------------------------------------------
module msc_seg_out (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cell_valid,
	input  msc_pkg::cell_t                        cell_in,
	input  logic [msc_pkg::NUM_EDGES-1:0][msc_pkg::FRAC_W-1:0] frac,
	output logic                                  take,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output msc_pkg::seg_t                         seg,
	output logic [msc_pkg::CASE_W-1:0]            case_index,
	output logic                                  last_segment
);
	import msc_pkg::*;

	logic        hold_q;
	logic        seg_q;
	logic        two_q;
	logic [CASE_W-1:0] idx_q;
	seg_t        seg0_q;
	seg_t        seg1_q;

	point_t      px [NUM_EDGES];
	point_t      py [NUM_EDGES];
	seg_t        seg0_nx;
	seg_t        seg1_nx;

	// crossing point per edge; right and top lines saturate past 255.0
	always_comb begin
		logic [POINT_W:0] bx, by, s;
		bx = {1'b0, cell_in.col, 8'h00};
		by = {1'b0, cell_in.row, 8'h00};
		for (int e = 0; e < NUM_EDGES; e++) begin
			px[e] = bx[POINT_W-1:0];
			py[e] = by[POINT_W-1:0];
		end
		s = bx + {{(POINT_W+1-FRAC_W){1'b0}}, frac[EDGE_BOTTOM]};
		px[EDGE_BOTTOM] = s[POINT_W-1:0];
		s = by + {{(POINT_W+1-FRAC_W){1'b0}}, frac[EDGE_LEFT]};
		py[EDGE_LEFT] = s[POINT_W-1:0];
		s = bx + (POINT_W+1)'(256);
		px[EDGE_RIGHT] = s[POINT_W] ? '1 : s[POINT_W-1:0];
		s = by + {{(POINT_W+1-FRAC_W){1'b0}}, frac[EDGE_RIGHT]};
		py[EDGE_RIGHT] = s[POINT_W-1:0];
		s = bx + {{(POINT_W+1-FRAC_W){1'b0}}, frac[EDGE_TOP]};
		px[EDGE_TOP] = s[POINT_W-1:0];
		s = by + (POINT_W+1)'(256);
		py[EDGE_TOP] = s[POINT_W] ? '1 : s[POINT_W-1:0];
	end

	// pick the endpoints of both segments by case
	always_comb begin
		edge_t e0, e1, e2, e3;
		e0 = seg_edge(cell_in.idx, 2'd0);
		e1 = seg_edge(cell_in.idx, 2'd1);
		e2 = seg_edge(cell_in.idx, 2'd2);
		e3 = seg_edge(cell_in.idx, 2'd3);
		seg0_nx = '{sx: px[e0], sy: py[e0], ex: px[e1], ey: py[e1]};
		seg1_nx = '{sx: px[e2], sy: py[e2], ex: px[e3], ey: py[e3]};
	end

	assign last_segment = !two_q || seg_q;
	assign out_valid    = hold_q;
	assign take         = !hold_q || (out_ready && last_segment);
	assign seg          = seg_q ? seg1_q : seg0_q;
	assign case_index   = idx_q;

	// control: hold a cell until its last segment transfers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			seg_q  <= 1'b0;
		end else if (take) begin
			hold_q <= cell_valid && (seg_count(cell_in.idx) != 2'd0);
			seg_q  <= 1'b0;
		end else if (out_ready) begin
			seg_q  <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (take) begin
			two_q  <= (seg_count(cell_in.idx) == 2'd2);
			idx_q  <= cell_in.idx;
			seg0_q <= seg0_nx;
			seg1_q <= seg1_nx;
		end
	end

	// a first segment of a two-segment cell is followed by its last
	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_segment |=> out_valid && last_segment)
		else $error("second segment missing");

	// empty cases never reach the output
	a_no_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (case_index != 4'd0) && (case_index != 4'd15))
		else $error("empty case emitted");

	// a stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(seg) && $stable(last_segment))
		else $error("stalled result changed");

endmodule

// ===== sv/marching_squares_cell_unit.sv =====
// ----------------------------------------------------------------------------
// marching_squares_cell_unit
// Marching squares cell: isoline segments with linear edge interpolation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one grid cell per transfer:
//   lower-left column/row and the four corner samples. Output channel
//   (out_valid/out_ready) carries one segment per transfer, endpoints in
//   8.8 grid units, with the cell's case index and last_segment set on the
//   final segment of the cell. A cell with all corners inside or all
//   outside produces no transfer; the two saddle cells produce two.
//   The first segment passes through six registers after the input transfer
//   (one prep stage, four divider stages retiring two quotient bits each,
//   one output register).
//   One cell per cycle for single-segment cells while out_ready is high; a
//   two-segment cell holds the single output port for both its segments.
//   Reset clears all valid bits; the pipeline is empty afterward.
//   When the receiver stalls, stages fill up behind the output register and
//   in_ready drops once every stage is occupied; nothing is lost.
// ----------------------------------------------------------------------------
module marching_squares_cell_unit #(
	parameter int unsigned GRID_CELLS  = msc_pkg::GRID_CELLS_DEF,
	parameter int unsigned SAMPLE_BITS = msc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [msc_pkg::COORD_W-1:0]           cell_col,
	input  logic [msc_pkg::COORD_W-1:0]           cell_row,
	input  logic signed [msc_pkg::SAMPLE_PORT_W-1:0] val_lower_left,
	input  logic signed [msc_pkg::SAMPLE_PORT_W-1:0] val_lower_right,
	input  logic signed [msc_pkg::SAMPLE_PORT_W-1:0] val_upper_right,
	input  logic signed [msc_pkg::SAMPLE_PORT_W-1:0] val_upper_left,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [msc_pkg::POINT_W-1:0]           start_x,
	output logic [msc_pkg::POINT_W-1:0]           start_y,
	output logic [msc_pkg::POINT_W-1:0]           end_x,
	output logic [msc_pkg::POINT_W-1:0]           end_y,
	output logic [msc_pkg::CASE_W-1:0]            case_index,
	output logic                                  last_segment
);
	import msc_pkg::*;

	localparam int unsigned SB = SAMPLE_BITS;
	localparam int unsigned DW = SB + 1;
	localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(GRID_CELLS - 1);

	logic signed [SB-1:0] smp [NUM_EDGES];
	logic [DW-1:0] num_nx [NUM_EDGES];
	logic [DW-1:0] den_nx [NUM_EDGES];
	cell_t         cell_nx;

	logic          vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic          rdy1, rdy2, rdy3, rdy4, rdy5;
	cell_t         cell_s1, cell_s2, cell_s3, cell_s4, cell_s5;
	logic [DW-1:0] num_s1 [NUM_EDGES];
	logic [DW-1:0] den_s1 [NUM_EDGES];

	logic [NUM_EDGES-1:0][FRAC_W-1:0] frac;
	logic          take;
	seg_t          seg;

	// sample width: low SAMPLE_BITS of the port, zero-filled above it
	always_comb begin
		logic [SB+SAMPLE_PORT_W-1:0] ext;
		ext = {{SB{1'b0}}, val_lower_left};  smp[0] = ext[SB-1:0];
		ext = {{SB{1'b0}}, val_lower_right}; smp[1] = ext[SB-1:0];
		ext = {{SB{1'b0}}, val_upper_right}; smp[2] = ext[SB-1:0];
		ext = {{SB{1'b0}}, val_upper_left};  smp[3] = ext[SB-1:0];
	end

	// prep: case index, clamped coordinates, |vs| and |vs - ve| per edge
	always_comb begin
		logic signed [DW-1:0] vs, ve, d;
		cell_nx.col = (32'(cell_col) >= GRID_CELLS) ? COORD_MAX : cell_col;
		cell_nx.row = (32'(cell_row) >= GRID_CELLS) ? COORD_MAX : cell_row;
		cell_nx.idx = {!smp[0][SB-1], !smp[1][SB-1], !smp[2][SB-1], !smp[3][SB-1]};
		for (int e = 0; e < NUM_EDGES; e++) begin
			case (e)
				EDGE_BOTTOM: begin vs = DW'(smp[0]); ve = DW'(smp[1]); end
				EDGE_LEFT:   begin vs = DW'(smp[0]); ve = DW'(smp[3]); end
				EDGE_RIGHT:  begin vs = DW'(smp[1]); ve = DW'(smp[2]); end
				default:     begin vs = DW'(smp[3]); ve = DW'(smp[2]); end
			endcase
			d = vs - ve;
			num_nx[e] = vs[DW-1] ? DW'(-vs) : DW'(vs);
			den_nx[e] = d[DW-1]  ? DW'(-d)  : DW'(d);
		end
	end

	// backpressure chain: a stage loads when empty or when its successor loads
	assign rdy5     = !vld_s5 || take;
	assign rdy4     = !vld_s4 || rdy5;
	assign rdy3     = !vld_s3 || rdy4;
	assign rdy2     = !vld_s2 || rdy3;
	assign rdy1     = !vld_s1 || rdy2;
	assign in_ready = rdy1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= in_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
		end
	end

	// cell payload beside the divider lanes
	always_ff @(posedge clk) begin
		if (rdy1) begin
			cell_s1 <= cell_nx;
			for (int e = 0; e < NUM_EDGES; e++) begin
				num_s1[e] <= num_nx[e];
				den_s1[e] <= den_nx[e];
			end
		end
		if (rdy2) cell_s2 <= cell_s1;
		if (rdy3) cell_s3 <= cell_s2;
		if (rdy4) cell_s4 <= cell_s3;
		if (rdy5) cell_s5 <= cell_s4;
	end

	// one divider lane per edge
	for (genvar e = 0; e < NUM_EDGES; e++) begin : g_lane
		msc_frac_div #(.DW(DW)) u_div (
			.clk  (clk),
			.en   ({rdy5, rdy4, rdy3, rdy2}),
			.num  (num_s1[e]),
			.den  (den_s1[e]),
			.frac (frac[e])
		);
	end

	msc_seg_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.cell_valid   (vld_s5),
		.cell_in      (cell_s5),
		.frac         (frac),
		.take         (take),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.seg          (seg),
		.case_index   (case_index),
		.last_segment (last_segment)
	);

	assign start_x = seg.sx;
	assign start_y = seg.sy;
	assign end_x   = seg.ex;
	assign end_y   = seg.ey;

	// a stalled last stage keeps its cell
	a_s5_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 && !rdy5 |=> vld_s5 && $stable(cell_s5))
		else $error("stage 5 lost its cell under stall");

	// input is refused only when every stage is occupied
	a_full_only: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && out_valid)
		else $error("input refused with a free stage");

	// an accepted cell reaches stage 2 next cycle when stage 2 is free
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && rdy2 |=> vld_s2)
		else $error("stage 1 cell dropped");

endmodule
